@@ hdl/csl_pkg.sv @@
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, token codes and character class helpers of the C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 6;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned ResCntW = 3;
  localparam int unsigned NumKw   = 16;

  localparam logic [ByteW-1:0] ResetMaxLen = 8'd80;

  localparam logic [KindW-1:0] KIND_NAME      = 6'd0;
  localparam logic [KindW-1:0] KIND_NUMBER    = 6'd1;
  localparam logic [KindW-1:0] KIND_STRING    = 6'd2;
  localparam logic [KindW-1:0] KIND_CHARACTER = 6'd3;
  localparam logic [KindW-1:0] KIND_LBRACE    = 6'd4;
  localparam logic [KindW-1:0] KIND_RBRACE    = 6'd5;
  localparam logic [KindW-1:0] KIND_SEMI      = 6'd6;
  localparam logic [KindW-1:0] KIND_PLUS      = 6'd7;
  localparam logic [KindW-1:0] KIND_MINUS     = 6'd8;
  localparam logic [KindW-1:0] KIND_STAR      = 6'd9;
  localparam logic [KindW-1:0] KIND_SLASH     = 6'd10;
  localparam logic [KindW-1:0] KIND_AMP       = 6'd11;
  localparam logic [KindW-1:0] KIND_PIPE      = 6'd12;
  localparam logic [KindW-1:0] KIND_AND_AND   = 6'd13;
  localparam logic [KindW-1:0] KIND_OR_OR     = 6'd14;
  localparam logic [KindW-1:0] KIND_ASSIGN    = 6'd15;
  localparam logic [KindW-1:0] KIND_EQ        = 6'd16;
  localparam logic [KindW-1:0] KIND_NOT       = 6'd17;
  localparam logic [KindW-1:0] KIND_NE        = 6'd19;
  localparam logic [KindW-1:0] KIND_LT        = 6'd20;
  localparam logic [KindW-1:0] KIND_GT        = 6'd21;
  localparam logic [KindW-1:0] KIND_LE        = 6'd22;
  localparam logic [KindW-1:0] KIND_GE        = 6'd23;
  localparam logic [KindW-1:0] KIND_ARROW     = 6'd24;
  localparam logic [KindW-1:0] KIND_DOT       = 6'd25;
  localparam logic [KindW-1:0] KIND_INC       = 6'd26;
  localparam logic [KindW-1:0] KIND_DEC       = 6'd27;
  localparam logic [KindW-1:0] KIND_COLON     = 6'd28;
  localparam logic [KindW-1:0] KIND_QUEST     = 6'd29;
  localparam logic [KindW-1:0] KIND_COMMA     = 6'd30;
  localparam logic [KindW-1:0] KIND_LPAREN    = 6'd31;
  localparam logic [KindW-1:0] KIND_RPAREN    = 6'd32;
  localparam logic [KindW-1:0] KIND_LBRACK    = 6'd33;
  localparam logic [KindW-1:0] KIND_RBRACK    = 6'd34;
  localparam logic [KindW-1:0] KIND_KW_BASE   = 6'd35;
  localparam logic [KindW-1:0] KIND_OTHER     = 6'd51;

  // Keywords are stored right-justified, as string literals are packed.
  localparam logic [63:0] KwText [NumKw] = '{
    "int", "if", "while", "return", "void", "else", "struct", "sizeof",
    "typedef", "char", "for", "switch", "case", "default", "break", "enum"
  };
  localparam logic [3:0] KwLen [NumKw] = '{
    4'd3, 4'd2, 4'd5, 4'd6, 4'd4, 4'd4, 4'd6, 4'd6,
    4'd7, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd4
  };

  typedef struct packed {
    logic             has_char;
    logic [ByteW-1:0] text_char;
    logic             token_done;
    logic [KindW-1:0] token_kind;
    logic             line_done;
    logic             last_result;
  } res_t;

  typedef struct packed {
    logic               push;
    logic [ResCntW-1:0] cnt;
    res_t [MaxRes-1:0]  res;
  } step_t;

  function automatic logic is_alpha(logic [ByteW-1:0] c);
    return (c == "_") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [ByteW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [ByteW-1:0] decode_esc(logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c == "n") r = 8'd10;
    else if (c == "t") r = 8'd9;
    else if (c == "0") r = 8'd0;
    return r;
  endfunction

  function automatic logic [KindW-1:0] single_kind(logic [ByteW-1:0] c);
    logic [KindW-1:0] k;
    unique case (c)
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ".":     k = KIND_DOT;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ",":     k = KIND_COMMA;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      ":":     k = KIND_COLON;
      "?":     k = KIND_QUEST;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "&":     k = KIND_AMP;
      "|":     k = KIND_PIPE;
      "=":     k = KIND_ASSIGN;
      ">":     k = KIND_GT;
      "<":     k = KIND_LT;
      "!":     k = KIND_NOT;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic may_pair(logic [ByteW-1:0] c);
    return (c == "/") || (c == "+") || (c == "-") || (c == "&") || (c == "|") ||
           (c == "=") || (c == ">") || (c == "<") || (c == "!");
  endfunction

  // Returns KIND_NAME when the two bytes form no operator.
  function automatic logic [KindW-1:0] pair_kind(logic [ByteW-1:0] a,
                                                 logic [ByteW-1:0] b);
    logic [KindW-1:0] k;
    k = KIND_NAME;
    if (a == "+" && b == "+") k = KIND_INC;
    else if (a == "-" && b == ">") k = KIND_ARROW;
    else if (a == "-" && b == "-") k = KIND_DEC;
    else if (a == "&" && b == "&") k = KIND_AND_AND;
    else if (a == "|" && b == "|") k = KIND_OR_OR;
    else if (a == "=" && b == "=") k = KIND_EQ;
    else if (a == ">" && b == "=") k = KIND_GE;
    else if (a == "<" && b == "=") k = KIND_LE;
    else if (a == "!" && b == "=") k = KIND_NE;
    return k;
  endfunction

  // One bit per keyword: the keyword has byte c at position p.
  function automatic logic [NumKw-1:0] kw_match(logic [ByteW-1:0] p,
                                                logic [ByteW-1:0] c);
    logic [NumKw-1:0] m;
    logic [2:0]       idx;
    for (int k = 0; k < NumKw; k++) begin
      idx  = 3'(KwLen[k] - 4'd1 - {1'b0, p[2:0]});
      m[k] = (p < {4'd0, KwLen[k]}) && (KwText[k][{idx, 3'b000} +: 8] == c);
    end
    return m;
  endfunction

  function automatic logic [KindW-1:0] name_kind(logic [NumKw-1:0] cand,
                                                 logic [ByteW-1:0] len);
    logic [KindW-1:0] k;
    k = KIND_NAME;
    for (int i = 0; i < NumKw; i++) begin
      if (cand[i] && ({4'd0, KwLen[i]} == len)) k = KIND_KW_BASE + KindW'(i);
    end
    return k;
  endfunction

endpackage

@@ hdl/csl_if.sv @@
// ----------------------------------------------------------------------------
// csl_if
// Valid/ready channels of the lexer: source bytes in, token results out.
// ----------------------------------------------------------------------------
interface csl_in_if import csl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface csl_out_if import csl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             has_char;
  logic [ByteW-1:0] text_char;
  logic             token_done;
  logic [KindW-1:0] token_kind;
  logic             line_done;
  logic             last_result;

  modport source (output valid, output has_char, output text_char, output token_done,
                  output token_kind, output line_done, output last_result,
                  input ready);
  modport sink (input valid, input has_char, input text_char, input token_done,
                input token_kind, input line_done, input last_result,
                output ready);
endinterface

@@ hdl/csl_core.sv @@
// ----------------------------------------------------------------------------
// csl_core
// Lexer state and the combinational step that turns one byte into its results.
// ----------------------------------------------------------------------------
module csl_core import csl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_data_i,
  csl_in_if.sink       in_i,
  input  logic         take_ok_i,
  output step_t        step_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_NAME, M_NUMBER, M_STRING, M_STRING_ESC,
    M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_SYMBOL, M_COMMENT
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [ByteW-1:0]   len_q, len_d;
  logic [NumKw-1:0]   cand_q, cand_d;
  logic [ByteW-1:0]   pend_q, pend_d;
  logic [ByteW-1:0]   max_len_q;
  logic               acc;
  logic [ResCntW-1:0] n;
  res_t [MaxRes-1:0]  r;

  function automatic res_t mk_char(logic [ByteW-1:0] c);
    res_t x;
    x           = '0;
    x.has_char  = 1'b1;
    x.text_char = c;
    return x;
  endfunction

  function automatic res_t mk_done(logic [KindW-1:0] k);
    res_t x;
    x            = '0;
    x.token_done = 1'b1;
    x.token_kind = k;
    return x;
  endfunction

  assign in_i.ready = take_ok_i;
  assign acc        = in_i.valid & take_ok_i;

  always_comb begin
    logic [ByteW-1:0] b;
    logic             do_idle;
    logic [KindW-1:0] pk;
    b       = in_i.source_byte;
    do_idle = 1'b0;
    pk      = pair_kind(pend_q, b);
    mode_d  = mode_q;
    len_d   = len_q;
    cand_d  = cand_q;
    pend_d  = pend_q;
    n       = '0;
    r       = '0;

    unique case (mode_q)
      M_NAME: begin
        if ((is_alpha(b) || is_digit(b)) && (len_q < max_len_q)) begin
          cand_d       = cand_q & kw_match(len_q, b);
          r[n[1:0]]    = mk_char(b);
          n            = n + 3'd1;
          len_d        = len_q + 8'd1;
        end else begin
          r[n[1:0]]    = mk_done(name_kind(cand_q, len_q));
          n            = n + 3'd1;
          do_idle      = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(b) && (len_q < max_len_q)) begin
          r[n[1:0]]    = mk_char(b);
          n            = n + 3'd1;
          len_d        = len_q + 8'd1;
        end else begin
          r[n[1:0]]    = mk_done(KIND_NUMBER);
          n            = n + 3'd1;
          do_idle      = 1'b1;
        end
      end
      M_STRING: begin
        if (b == 8'd0) begin
          r[n[1:0]] = mk_done(KIND_STRING);
          n         = n + 3'd1;
          do_idle   = 1'b1;
        end else if (b == "\"") begin
          r[n[1:0]] = mk_done(KIND_STRING);
          n         = n + 3'd1;
          mode_d    = M_IDLE;
        end else if (b == "\\") begin
          mode_d    = M_STRING_ESC;
        end else begin
          r[n[1:0]] = mk_char(b);
          n         = n + 3'd1;
        end
      end
      M_STRING_ESC: begin
        if (b == 8'd0) begin
          r[n[1:0]] = mk_done(KIND_STRING);
          n         = n + 3'd1;
          do_idle   = 1'b1;
        end else begin
          r[n[1:0]] = mk_char(decode_esc(b));
          n         = n + 3'd1;
          mode_d    = M_STRING;
        end
      end
      M_CHAR_OPEN: begin
        if (b == 8'd0) begin
          r[n[1:0]] = mk_done(KIND_CHARACTER);
          n         = n + 3'd1;
          do_idle   = 1'b1;
        end else if (b == "\\") begin
          mode_d    = M_CHAR_ESC;
        end else begin
          r[n[1:0]] = mk_char(b);
          n         = n + 3'd1;
          mode_d    = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (b == 8'd0) begin
          r[n[1:0]] = mk_done(KIND_CHARACTER);
          n         = n + 3'd1;
          do_idle   = 1'b1;
        end else begin
          r[n[1:0]] = mk_char(decode_esc(b));
          n         = n + 3'd1;
          mode_d    = M_CHAR_CLOSE;
        end
      end
      M_CHAR_CLOSE: begin
        r[n[1:0]] = mk_done(KIND_CHARACTER);
        n         = n + 3'd1;
        if (b == 8'd0) do_idle = 1'b1;
        else mode_d = M_IDLE;
      end
      M_SYMBOL: begin
        if (pk != KIND_NAME) begin
          r[n[1:0]] = mk_char(pend_q);
          n         = n + 3'd1;
          r[n[1:0]] = mk_char(b);
          n         = n + 3'd1;
          r[n[1:0]] = mk_done(pk);
          n         = n + 3'd1;
          pend_d    = '0;
          mode_d    = M_IDLE;
        end else if (pend_q == "/" && b == "/") begin
          pend_d    = '0;
          mode_d    = M_COMMENT;
        end else begin
          r[n[1:0]] = mk_char(pend_q);
          n         = n + 3'd1;
          r[n[1:0]] = mk_done(single_kind(pend_q));
          n         = n + 3'd1;
          do_idle   = 1'b1;
        end
      end
      M_COMMENT: begin
        if (b == 8'd0) do_idle = 1'b1;
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_d = M_IDLE;
      pend_d = '0;
      priority if (b == 8'd0) begin
        r[n[1:0]]           = '0;
        r[n[1:0]].line_done = 1'b1;
        n                   = n + 3'd1;
      end else if (b == " " || b == "\t" || b == "\n") begin
        mode_d = M_IDLE;
      end else if (b == "#") begin
        mode_d = M_COMMENT;
      end else if (is_alpha(b)) begin
        cand_d    = kw_match(8'd0, b);
        r[n[1:0]] = mk_char(b);
        n         = n + 3'd1;
        len_d     = 8'd1;
        mode_d    = M_NAME;
      end else if (is_digit(b)) begin
        r[n[1:0]] = mk_char(b);
        n         = n + 3'd1;
        len_d     = 8'd1;
        mode_d    = M_NUMBER;
      end else if (b == "\"") begin
        mode_d = M_STRING;
      end else if (b == "'") begin
        mode_d = M_CHAR_OPEN;
      end else if (may_pair(b)) begin
        pend_d = b;
        mode_d = M_SYMBOL;
      end else begin
        r[n[1:0]] = mk_char(b);
        n         = n + 3'd1;
        r[n[1:0]] = mk_done(single_kind(b));
        n         = n + 3'd1;
      end
    end

    for (int i = 0; i < MaxRes; i++) begin
      r[i].last_result = (ResCntW'(i + 1) == n);
    end
  end

  assign step_o.push = acc;
  assign step_o.cnt  = n;
  assign step_o.res  = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      len_q     <= '0;
      cand_q    <= '1;
      pend_q    <= '0;
      max_len_q <= ResetMaxLen;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_data_i;
      if (acc) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        cand_q <= cand_d;
        pend_q <= pend_d;
      end
    end
  end

endmodule

@@ hdl/csl_obuf.sv @@
// ----------------------------------------------------------------------------
// csl_obuf
// Result register that holds the results of one byte and sends them in order.
// ----------------------------------------------------------------------------
module csl_obuf import csl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  step_t        step_i,
  output logic         take_ok_o,
  csl_out_if.source    out_o
);

  res_t [MaxRes-1:0]  res_q;
  logic [ResCntW-1:0] left_q;
  logic [1:0]         rd_q;
  logic               xfer;
  res_t               cur;

  assign xfer      = out_o.valid & out_o.ready;
  assign take_ok_o = (left_q == '0) || ((left_q == ResCntW'(1)) && out_o.ready);
  assign cur       = res_q[rd_q];

  assign out_o.valid       = (left_q != '0);
  assign out_o.has_char    = cur.has_char;
  assign out_o.text_char   = cur.text_char;
  assign out_o.token_done  = cur.token_done;
  assign out_o.token_kind  = cur.token_kind;
  assign out_o.line_done   = cur.line_done;
  assign out_o.last_result = cur.last_result;

  always_ff @(posedge clk_i) begin
    if (step_i.push) res_q <= step_i.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rd_q   <= '0;
    end else if (step_i.push) begin
      left_q <= step_i.cnt;
      rd_q   <= '0;
    end else if (xfer) begin
      left_q <= left_q - ResCntW'(1);
      rd_q   <= rd_q + 2'd1;
    end
  end

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, left_q} + {2'b00, rd_q}) <= 4'(MaxRes))
    else $error("result count overruns the buffer");

  a_push_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.push |-> (left_q == '0) || (left_q == ResCntW'(1) && xfer))
    else $error("new results would overwrite pending ones");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_result == (left_q == ResCntW'(1))))
    else $error("last_result mark does not match the final result");

  a_line_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.line_done) |->
      (out_o.last_result && !out_o.has_char && !out_o.token_done))
    else $error("line end result shares fields with a token result");

endmodule

@@ hdl/c_subset_lexer.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer
// Splits a byte stream into tokens of a small C subset, one character a result.
// ----------------------------------------------------------------------------
// Usage:
// Source bytes arrive on in_i, one per transfer; a zero byte ends the line.
// Each accepted byte causes zero to four results on out_o, sent one per
// transfer in order. A result carries either one text character of the
// current token, a done mark with the token kind, or the line-end mark;
// last_result flags the final result of the byte.
// The results of a byte are registered and shown from the cycle after it is
// accepted on. A byte is accepted every cycle as long as the previous byte
// left no result waiting, or only its last one and out_o takes it in that
// cycle; throughput is one byte a cycle when bytes cause at most one result
// and out_o does not stall. cfg_we_i writes max_token_length from cfg_data_i;
// the user must do so only while the block is idle, which it does not
// enforce. Reset clears the lexer to the state between tokens and sets the
// length limit to 80. When out_o stalls, the held results stay put and
// in_i.ready stays low until the last held result is taken in the same cycle.
// ----------------------------------------------------------------------------
module c_subset_lexer import csl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  csl_in_if.sink     in_i,
  csl_out_if.source  out_o
);

  step_t step;
  logic  take_ok;

  csl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .take_ok_i  (take_ok),
    .step_o     (step)
  );

  csl_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .take_ok_o (take_ok),
    .out_o     (out_o)
  );

endmodule
